>>> sv/md5_pkg.sv
// Shared types, constants and round tables for the MD5 message digest block.
package md5_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last;
    } out_t;

    // Write port of the block buffer.
    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } buf_wr_t;

    localparam logic        KIND_DATA   = 1'b0;
    localparam logic        KIND_FINISH = 1'b1;

    localparam logic [31:0] CHAIN_INIT_A = 32'h67452301;
    localparam logic [31:0] CHAIN_INIT_B = 32'hefcdab89;
    localparam logic [31:0] CHAIN_INIT_C = 32'h98badcfe;
    localparam logic [31:0] CHAIN_INIT_D = 32'h10325476;

    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [5:0]  BLOCK_LAST  = 6'h3f;
    localparam logic [5:0]  LEN_OFFSET  = 6'd56;
    localparam logic [5:0]  ROUND_LAST  = 6'd63;
    localparam logic [63:0] BYTE_BITS   = 64'd8;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [9:0] prod;
        begin
            case (rnd[5:4])
                2'd0:    prod = {4'd0, rnd};
                2'd1:    prod = 10'd5 * {4'd0, rnd} + 10'd1;
                2'd2:    prod = 10'd3 * {4'd0, rnd} + 10'd5;
                default: prod = 10'd7 * {4'd0, rnd};
            endcase
            return prod[3:0];
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        return ROT_S[{rnd[5:4], rnd[1:0]}];
    endfunction

endpackage

>>> sv/md5_buf.sv
// Block buffer: sixteen 32-bit words, byte write port, registered word read.
module md5_buf (
    input  logic            aclk,
    input  md5_pkg::buf_wr_t wr,
    input  logic [3:0]      rd_addr,
    output logic [31:0]     rd_data
);

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[5:2]][8*wr.addr[1:0] +: 8] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/md5_round.sv
// One MD5 round step: boolean function, four-way add, rotate and final add.
module md5_round (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] w,
    input  logic [5:0]  rnd,
    output logic [31:0] new_b
);

    logic [31:0] f;
    logic [31:0] t;
    logic [63:0] rot;

    always_comb begin
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        t     = a + f + w + md5_pkg::ROUND_K[rnd];
        rot   = {t, t} << md5_pkg::rot_amount(rnd);
        new_b = b + rot[63:32];
    end

endmodule

>>> sv/md5_message_digest_top.sv
// Top level of the streaming MD5 message digest block.
//
// Streaming MD5 (RFC 1321). Each input transaction carries either one message
// byte (kind 0) or an end-of-message marker (kind 1, data_byte ignored).
// Bytes are packed little-endian into a 64-byte block buffer; the byte that
// fills a block starts the compression (a prefetch of the first message word,
// 64 rounds at one round per cycle through a single shared round unit, then
// an add of the working words into the chaining words). The round unit and
// the single read port of the block buffer set the pace of the compression.
// An end-of-message transaction writes the padding one byte per cycle (0x80,
// zeros up to offset 56, the 64-bit bit length little-endian), which takes
// one or two compressions in all, then returns four result transactions:
// digest words A, B, C, D with word_index 0..3 and last set on the fourth.
// After the fourth word is loaded the block returns to the standard starting
// state and takes the next message while that word still waits to be taken.
// s_ready is low while a block is being compressed, padded or its digest is
// emitted.
module md5_message_digest_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  md5_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output md5_pkg::out_t m_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_PREF  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   chain_reg [4];
    logic [31:0]   chain_next [4];
    logic [31:0]   a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [5:0]    round_reg, round_next;
    logic [63:0]   bit_len_reg, bit_len_next;
    logic [5:0]    pad_pos_reg, pad_pos_next;
    logic          len_phase_reg, len_phase_next;
    logic          fin_reg, fin_next;
    logic [1:0]    out_idx_reg, out_idx_next;
    logic          m_valid_reg, m_valid_next;
    md5_pkg::out_t m_data_reg, m_data_next;

    md5_pkg::buf_wr_t buf_wr;
    logic [3:0]       rd_addr;
    logic [31:0]      rd_word;
    logic [31:0]      round_b;
    logic             s_fire;
    logic             len_eff;
    logic [5:0]       round_inc;

    md5_buf u_buf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    md5_round u_round (
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .w     (rd_word),
        .rnd   (round_reg),
        .new_b (round_b)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign len_eff   = len_phase_reg || (pad_pos_reg == md5_pkg::LEN_OFFSET);
    assign round_inc = round_reg + 6'd1;

    // Fetch the word of the next round so that the registered read returns it in the cycle in which that round runs.
    assign rd_addr = (state_reg == ST_ROUND) ? md5_pkg::msg_index(round_inc)
                                             : md5_pkg::msg_index(6'd0);

    always_comb begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        round_next     = round_reg;
        bit_len_next   = bit_len_reg;
        pad_pos_next   = pad_pos_reg;
        len_phase_next = len_phase_reg;
        fin_next       = fin_reg;
        out_idx_next   = out_idx_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        buf_wr.en      = 1'b0;
        buf_wr.addr    = bit_len_reg[8:3];
        buf_wr.data    = s_data.data_byte;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    buf_wr.en = 1'b1;
                    if (s_data.kind == md5_pkg::KIND_DATA) begin
                        bit_len_next = bit_len_reg + md5_pkg::BYTE_BITS;
                        if (bit_len_reg[8:3] == md5_pkg::BLOCK_LAST) begin
                            state_next = ST_PREF;
                        end
                    end else begin
                        // Place the pad mark, then walk the rest of the padding.
                        buf_wr.data    = md5_pkg::PAD_MARK;
                        fin_next       = 1'b1;
                        len_phase_next = 1'b0;
                        pad_pos_next   = bit_len_reg[8:3] + 6'd1;
                        state_next     = (bit_len_reg[8:3] == md5_pkg::BLOCK_LAST) ?
                                         ST_PREF : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                buf_wr.en      = 1'b1;
                buf_wr.addr    = pad_pos_reg;
                buf_wr.data    = len_eff ? bit_len_reg[8*pad_pos_reg[2:0] +: 8] : 8'd0;
                len_phase_next = len_eff;
                pad_pos_next   = pad_pos_reg + 6'd1;
                if (pad_pos_reg == md5_pkg::BLOCK_LAST) begin
                    state_next = ST_PREF;
                end
            end
            ST_PREF: begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = round_b;
                round_next = round_inc;
                if (round_reg == md5_pkg::ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (len_phase_reg) begin
                    out_idx_next = 2'd0;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                // Load the next digest word once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.digest_word = chain_reg[out_idx_reg];
                    m_data_next.word_index  = out_idx_reg;
                    m_data_next.last        = (out_idx_reg == 2'd3);
                    out_idx_next            = out_idx_reg + 2'd1;
                    if (out_idx_reg == 2'd3) begin
                        chain_next[0]  = md5_pkg::CHAIN_INIT_A;
                        chain_next[1]  = md5_pkg::CHAIN_INIT_B;
                        chain_next[2]  = md5_pkg::CHAIN_INIT_C;
                        chain_next[3]  = md5_pkg::CHAIN_INIT_D;
                        bit_len_next   = 64'd0;
                        fin_next       = 1'b0;
                        len_phase_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= md5_pkg::CHAIN_INIT_A;
            chain_reg[1]  <= md5_pkg::CHAIN_INIT_B;
            chain_reg[2]  <= md5_pkg::CHAIN_INIT_C;
            chain_reg[3]  <= md5_pkg::CHAIN_INIT_D;
            round_reg     <= 6'd0;
            bit_len_reg   <= 64'd0;
            pad_pos_reg   <= 6'd0;
            len_phase_reg <= 1'b0;
            fin_reg       <= 1'b0;
            out_idx_reg   <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            round_reg     <= round_next;
            bit_len_reg   <= bit_len_next;
            pad_pos_reg   <= pad_pos_next;
            len_phase_reg <= len_phase_next;
            fin_reg       <= fin_next;
            out_idx_reg   <= out_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Working words and the output payload hold without reset.
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_pref_round0: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PREF |=> round_reg == 6'd0 && state_reg == ST_ROUND)
        else $error("compression did not start at round zero");

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == md5_pkg::ROUND_LAST) |=>
        state_reg == ST_ADD)
        else $error("compression did not end after the last round");

    a_out_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> fin_reg && len_phase_reg)
        else $error("digest emitted before padding completed");

    a_len_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD && len_phase_reg) |-> pad_pos_reg[5:3] == 3'b111)
        else $error("length bytes outside the last eight block bytes");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND || state_reg == ST_PAD) |-> !s_ready)
        else $error("input accepted while a block is in progress");
`endif

endmodule
